### hdl/pfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pfr_pkg;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_REQ  = 2'd1;
  localparam logic [1:0] PH_TALK = 2'd2;
  localparam logic [1:0] PH_END  = 2'd3;

  localparam logic [2:0] EV_TICK  = 3'd0;
  localparam logic [2:0] EV_DOWN  = 3'd1;
  localparam logic [2:0] EV_UP    = 3'd2;
  localparam logic [2:0] EV_GRANT = 3'd3;
  localparam logic [2:0] EV_DENY  = 3'd4;
  localparam logic [2:0] EV_VOICE = 3'd5;
  localparam logic [2:0] EV_LOSS  = 3'd6;

  localparam logic [2:0] REG_GRANT_TIMEOUT   = 3'd0;
  localparam logic [2:0] REG_REQUEST_LIMIT   = 3'd1;
  localparam logic [2:0] REG_RENEW_INTERVAL  = 3'd2;
  localparam logic [2:0] REG_MAX_TALK        = 3'd3;
  localparam logic [2:0] REG_END_BURST       = 3'd4;
  localparam logic [2:0] REG_END_INTERVAL    = 3'd5;
  localparam logic [2:0] REG_FIRST_STREAM    = 3'd6;

  localparam logic [31:0] GRANT_TIMEOUT_RST   = 32'd100;
  localparam logic [7:0]  REQUEST_LIMIT_RST   = 8'd3;
  localparam logic [31:0] RENEW_INTERVAL_RST  = 32'd250;
  localparam logic [31:0] MAX_TALK_RST        = 32'd120000;
  localparam logic [7:0]  END_BURST_RST       = 8'd3;
  localparam logic [31:0] END_INTERVAL_RST    = 32'd50;

  typedef struct packed {
    logic [31:0] grant_timeout;
    logic [7:0]  request_limit;
    logic [31:0] renew_interval;
    logic [31:0] max_talk;
    logic [7:0]  end_burst;
    logic [31:0] end_interval;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] entered_time;
    logic [31:0] talk_start_time;
    logic [31:0] last_renew_time;
    logic [31:0] last_end_time;
    logic [7:0]  requests_count;
    logic [7:0]  ends_count;
    logic [31:0] stream_now;
    logic [31:0] stream_next;
  } state_t;

  typedef struct packed {
    logic send_request;
    logic send_end;
    logic send_renew;
    logic start_tx;
    logic stop_tx;
    logic indicate_grant;
    logic indicate_fail;
    logic warn_max_talk;
  } act_t;

endpackage
`default_nettype wire

### hdl/pfr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module pfr_cfg (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_write,
  input  wire [2:0]        cfg_index,
  input  wire [31:0]       cfg_data,
  output pfr_pkg::cfg_t    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grant_timeout   <= pfr_pkg::GRANT_TIMEOUT_RST;
      cfg.request_limit   <= pfr_pkg::REQUEST_LIMIT_RST;
      cfg.renew_interval  <= pfr_pkg::RENEW_INTERVAL_RST;
      cfg.max_talk        <= pfr_pkg::MAX_TALK_RST;
      cfg.end_burst       <= pfr_pkg::END_BURST_RST;
      cfg.end_interval    <= pfr_pkg::END_INTERVAL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        pfr_pkg::REG_GRANT_TIMEOUT:   cfg.grant_timeout   <= cfg_data;
        pfr_pkg::REG_REQUEST_LIMIT:   cfg.request_limit   <= cfg_data[7:0];
        pfr_pkg::REG_RENEW_INTERVAL:  cfg.renew_interval  <= cfg_data;
        pfr_pkg::REG_MAX_TALK:        cfg.max_talk        <= cfg_data;
        pfr_pkg::REG_END_BURST:       cfg.end_burst       <= cfg_data[7:0];
        pfr_pkg::REG_END_INTERVAL:    cfg.end_interval    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/pfr_step.sv
`timescale 1ns / 1ps
`default_nettype none
module pfr_step (
  input  wire pfr_pkg::cfg_t   cfg,
  input  wire pfr_pkg::state_t st,
  input  wire [2:0]        mode,
  input  wire [31:0]       now,
  output pfr_pkg::state_t  st_next,
  output pfr_pkg::act_t    act
);

  function automatic logic waited(input logic [31:0] t, input logic [31:0] since,
                                  input logic [31:0] span);
    logic [31:0] d;
    d = t - since;
    return d >= span;
  endfunction

  logic        grant_expired;
  logic        talk_expired;
  logic        renew_due;
  logic        end_due;
  logic [31:0] stream_inc;

  assign grant_expired = waited(now, st.entered_time, cfg.grant_timeout);
  assign talk_expired  = waited(now, st.talk_start_time, cfg.max_talk);
  assign renew_due     = waited(now, st.last_renew_time, cfg.renew_interval);
  assign end_due       = waited(now, st.last_end_time, cfg.end_interval);
  assign stream_inc    = st.stream_next + 32'd1;

  always_comb begin
    st_next = st;
    act     = '0;
    if (mode == pfr_pkg::EV_LOSS) begin
      if (st.phase != pfr_pkg::PH_IDLE) begin
        st_next.phase        = pfr_pkg::PH_IDLE;
        st_next.entered_time = now;
        act.stop_tx          = 1'b1;
        act.indicate_fail    = 1'b1;
      end
    end else begin
      case (st.phase)
        pfr_pkg::PH_IDLE, pfr_pkg::PH_END: begin
          if (mode == pfr_pkg::EV_DOWN) begin
            st_next.stream_now     = st.stream_next;
            st_next.stream_next    = (stream_inc == 32'd0) ? 32'd1 : stream_inc;
            st_next.requests_count = 8'd1;
            st_next.phase          = pfr_pkg::PH_REQ;
            st_next.entered_time   = now;
            act.send_request       = 1'b1;
          end else if (st.phase == pfr_pkg::PH_END && mode == pfr_pkg::EV_TICK &&
                       end_due) begin
            if (st.ends_count < cfg.end_burst) begin
              st_next.ends_count    = st.ends_count + 8'd1;
              st_next.last_end_time = now;
              act.send_end          = 1'b1;
            end else begin
              st_next.phase        = pfr_pkg::PH_IDLE;
              st_next.entered_time = now;
            end
          end
        end
        pfr_pkg::PH_REQ: begin
          case (mode)
            pfr_pkg::EV_UP: begin
              st_next.phase         = pfr_pkg::PH_END;
              st_next.entered_time  = now;
              st_next.ends_count    = 8'd1;
              st_next.last_end_time = now;
              act.send_end          = 1'b1;
            end
            pfr_pkg::EV_GRANT: begin
              st_next.phase           = pfr_pkg::PH_TALK;
              st_next.entered_time    = now;
              st_next.talk_start_time = now;
              st_next.last_renew_time = now;
              act.start_tx            = 1'b1;
              act.indicate_grant      = 1'b1;
            end
            pfr_pkg::EV_DENY: begin
              st_next.phase        = pfr_pkg::PH_IDLE;
              st_next.entered_time = now;
              act.indicate_fail    = 1'b1;
            end
            pfr_pkg::EV_TICK: begin
              if (grant_expired) begin
                st_next.entered_time = now;
                if (st.requests_count < cfg.request_limit) begin
                  st_next.requests_count = st.requests_count + 8'd1;
                  act.send_request       = 1'b1;
                end else begin
                  st_next.phase     = pfr_pkg::PH_IDLE;
                  act.indicate_fail = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        pfr_pkg::PH_TALK: begin
          case (mode)
            pfr_pkg::EV_UP: begin
              st_next.phase         = pfr_pkg::PH_END;
              st_next.entered_time  = now;
              st_next.ends_count    = 8'd1;
              st_next.last_end_time = now;
              act.stop_tx           = 1'b1;
              act.send_end          = 1'b1;
            end
            pfr_pkg::EV_DENY: begin
              st_next.phase        = pfr_pkg::PH_IDLE;
              st_next.entered_time = now;
              act.stop_tx          = 1'b1;
              act.indicate_fail    = 1'b1;
            end
            pfr_pkg::EV_VOICE: st_next.last_renew_time = now;
            pfr_pkg::EV_TICK: begin
              if (talk_expired) begin
                st_next.phase         = pfr_pkg::PH_END;
                st_next.entered_time  = now;
                st_next.ends_count    = 8'd1;
                st_next.last_end_time = now;
                act.stop_tx           = 1'b1;
                act.send_end          = 1'b1;
                act.warn_max_talk     = 1'b1;
              end else if (renew_due) begin
                st_next.last_renew_time = now;
                act.send_renew          = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/ptt_floor_request_node.sv
`timescale 1ns / 1ps
`default_nettype none
// Push-to-talk floor request node. Each event word (mode, now) yields exactly
// one result word: action flags, the current stream id and the phase after
// the event. An event is captured in an input register, evaluated against the
// phase and timers combinationally, and lands in the result register; one
// event is taken every cycle unless out_ready holds a waiting result, and the
// input register can take one more word while a result waits. Timeouts use
// wrapping 32-bit differences. Writing first_stream reloads the stream counter
// (zero loads one); write configuration only while no word is in flight.
module ptt_floor_request_node (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_write,
  input  wire [2:0]  cfg_index,
  input  wire [31:0] cfg_data,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [2:0]  mode,
  input  wire [31:0] now,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       send_request,
  output logic       send_end,
  output logic       send_renew,
  output logic       start_tx,
  output logic       stop_tx,
  output logic       indicate_grant,
  output logic       indicate_fail,
  output logic       warn_max_talk,
  output logic [31:0] current_stream,
  output logic [1:0] node_state
);

  pfr_pkg::cfg_t   cfg;
  pfr_pkg::state_t st;
  pfr_pkg::state_t st_next;
  pfr_pkg::act_t   act;

  logic        hold_valid;
  logic [2:0]  hold_mode;
  logic [31:0] hold_now;
  logic        advance;

  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  pfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pfr_step u_step (
    .cfg     (cfg),
    .st      (st),
    .mode    (hold_mode),
    .now     (hold_now),
    .st_next (st_next),
    .act     (act)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold_mode <= mode;
      hold_now  <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase           <= pfr_pkg::PH_IDLE;
      st.entered_time    <= '0;
      st.talk_start_time <= '0;
      st.last_renew_time <= '0;
      st.last_end_time   <= '0;
      st.requests_count  <= '0;
      st.ends_count      <= '0;
      st.stream_now      <= '0;
      st.stream_next     <= 32'd1;
    end else if (cfg_write && cfg_index == pfr_pkg::REG_FIRST_STREAM) begin
      st.stream_next <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      send_request   <= act.send_request;
      send_end       <= act.send_end;
      send_renew     <= act.send_renew;
      start_tx       <= act.start_tx;
      stop_tx        <= act.stop_tx;
      indicate_grant <= act.indicate_grant;
      indicate_fail  <= act.indicate_fail;
      warn_max_talk  <= act.warn_max_talk;
      current_stream <= st_next.stream_now;
      node_state     <= st_next.phase;
    end
  end

endmodule
`default_nettype wire

### sim/floor_node_checker.sv
`timescale 1ns / 1ps
module floor_node_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_write,
  input  wire [2:0]  cfg_index,
  input  wire [31:0] cfg_data,
  input  wire        in_valid,
  input  wire        in_ready,
  input  wire [2:0]  mode,
  input  wire [31:0] now,
  input  wire        out_valid,
  input  wire        out_ready,
  input  wire        send_request,
  input  wire        send_end,
  input  wire        send_renew,
  input  wire        start_tx,
  input  wire        stop_tx,
  input  wire        indicate_grant,
  input  wire        indicate_fail,
  input  wire        warn_max_talk,
  input  wire [31:0] current_stream,
  input  wire [1:0]  node_state,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    pfr_pkg::act_t act;
    logic [31:0]   stream;
    logic [1:0]    phase;
  } node_word_t;

  logic [31:0] grant_wait, renew_wait, talk_limit, end_wait;
  logic [7:0]  retry_limit, end_limit;

  logic [1:0]  ph;
  logic [31:0] entered_at, talk_start_at, renew_at, end_at;
  logic [7:0]  req_sent, end_sent;
  logic [31:0] stream_cur, stream_nxt;

  node_word_t results_due[$];

  function automatic bit elapsed(input logic [31:0] t, since, span);
    logic [31:0] gap;
    gap = t - since;
    return gap >= span;
  endfunction

  function automatic pfr_pkg::act_t begin_end_burst(input logic [31:0] t);
    pfr_pkg::act_t a;
    a = '0;
    ph = pfr_pkg::PH_END;
    entered_at = t;
    end_sent = 8'd1;
    end_at = t;
    a.stop_tx = 1'b1;
    a.send_end = 1'b1;
    return a;
  endfunction

  function automatic pfr_pkg::act_t drop_floor(input logic [31:0] t);
    pfr_pkg::act_t a;
    a = '0;
    ph = pfr_pkg::PH_IDLE;
    entered_at = t;
    a.stop_tx = 1'b1;
    a.indicate_fail = 1'b1;
    return a;
  endfunction

  function automatic pfr_pkg::act_t open_request(input logic [31:0] t);
    pfr_pkg::act_t a;
    a = '0;
    stream_cur = stream_nxt;
    stream_nxt = stream_nxt + 32'd1;
    if (stream_nxt == 32'd0) stream_nxt = 32'd1;
    req_sent = 8'd1;
    ph = pfr_pkg::PH_REQ;
    entered_at = t;
    a.send_request = 1'b1;
    return a;
  endfunction

  function automatic node_word_t advance_floor(input logic [2:0] ev, input logic [31:0] t);
    pfr_pkg::act_t a;
    node_word_t    w;
    a = '0;
    if (ev == pfr_pkg::EV_LOSS) begin
      if (ph != pfr_pkg::PH_IDLE) a = drop_floor(t);
    end else begin
      case (ph)
        pfr_pkg::PH_IDLE: begin
          if (ev == pfr_pkg::EV_DOWN) a = open_request(t);
        end
        pfr_pkg::PH_REQ: begin
          if (ev == pfr_pkg::EV_UP) begin
            a = begin_end_burst(t);
            a.stop_tx = 1'b0;
          end else if (ev == pfr_pkg::EV_GRANT) begin
            ph = pfr_pkg::PH_TALK;
            entered_at = t;
            talk_start_at = t;
            renew_at = t;
            a.start_tx = 1'b1;
            a.indicate_grant = 1'b1;
          end else if (ev == pfr_pkg::EV_DENY) begin
            a = drop_floor(t);
            a.stop_tx = 1'b0;
          end else if (ev == pfr_pkg::EV_TICK && elapsed(t, entered_at, grant_wait)) begin
            if (req_sent < retry_limit) begin
              req_sent = req_sent + 8'd1;
              entered_at = t;
              a.send_request = 1'b1;
            end else begin
              a = drop_floor(t);
              a.stop_tx = 1'b0;
            end
          end
        end
        pfr_pkg::PH_TALK: begin
          if (ev == pfr_pkg::EV_UP) begin
            a = begin_end_burst(t);
          end else if (ev == pfr_pkg::EV_DENY) begin
            a = drop_floor(t);
          end else if (ev == pfr_pkg::EV_VOICE) begin
            renew_at = t;
          end else if (ev == pfr_pkg::EV_TICK) begin
            if (elapsed(t, talk_start_at, talk_limit)) begin
              a = begin_end_burst(t);
              a.warn_max_talk = 1'b1;
            end else if (elapsed(t, renew_at, renew_wait)) begin
              renew_at = t;
              a.send_renew = 1'b1;
            end
          end
        end
        default: begin
          if (ev == pfr_pkg::EV_DOWN) begin
            a = open_request(t);
          end else if (ev == pfr_pkg::EV_TICK && elapsed(t, end_at, end_wait)) begin
            if (end_sent < end_limit) begin
              end_sent = end_sent + 8'd1;
              end_at = t;
              a.send_end = 1'b1;
            end else begin
              ph = pfr_pkg::PH_IDLE;
              entered_at = t;
            end
          end
        end
      endcase
    end
    w.act = a;
    w.stream = stream_cur;
    w.phase = ph;
    return w;
  endfunction

  always @(posedge clk) begin : watch
    node_word_t got, want;
    if (rst) begin
      grant_wait = pfr_pkg::GRANT_TIMEOUT_RST;
      retry_limit = pfr_pkg::REQUEST_LIMIT_RST;
      renew_wait = pfr_pkg::RENEW_INTERVAL_RST;
      talk_limit = pfr_pkg::MAX_TALK_RST;
      end_limit = pfr_pkg::END_BURST_RST;
      end_wait = pfr_pkg::END_INTERVAL_RST;
      ph = pfr_pkg::PH_IDLE;
      entered_at = '0;
      talk_start_at = '0;
      renew_at = '0;
      end_at = '0;
      req_sent = '0;
      end_sent = '0;
      stream_cur = '0;
      stream_nxt = 32'd1;
      results_due.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.act = {send_request, send_end, send_renew, start_tx, stop_tx,
                   indicate_grant, indicate_fail, warn_max_talk};
        got.stream = current_stream;
        got.phase = node_state;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word flags=%b stream=%h state=%0d",
                     $realtime, got.act, got.stream, got.phase);
        end else begin
          want = results_due.pop_front();
          if (got.act !== want.act || got.stream !== want.stream ||
              got.phase !== want.phase) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch flags(req,end,renew,start,stop,grant,fail,warn) %s",
                       $realtime, $sformatf("expected %b/%h/%0d got %b/%h/%0d",
                       want.act, want.stream, want.phase,
                       got.act, got.stream, got.phase));
          end
        end
      end
      if (in_valid && in_ready) results_due.push_back(advance_floor(mode, now));
      if (cfg_write) begin
        case (cfg_index)
          pfr_pkg::REG_GRANT_TIMEOUT:  grant_wait = cfg_data;
          pfr_pkg::REG_REQUEST_LIMIT:  retry_limit = cfg_data[7:0];
          pfr_pkg::REG_RENEW_INTERVAL: renew_wait = cfg_data;
          pfr_pkg::REG_MAX_TALK:       talk_limit = cfg_data;
          pfr_pkg::REG_END_BURST:      end_limit = cfg_data[7:0];
          pfr_pkg::REG_END_INTERVAL:   end_wait = cfg_data;
          pfr_pkg::REG_FIRST_STREAM:   stream_nxt = (cfg_data == 32'd0) ? 32'd1 : cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = results_due.size();
  end

endmodule

### sim/tb_ptt_floor_request_node.sv
`timescale 1ns / 1ps
module tb_ptt_floor_request_node;

  localparam logic [2:0] EV_NONE    = 3'd7;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk, rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid, in_ready;
  logic [2:0]  mode;
  logic [31:0] now;
  logic        out_valid, out_ready;
  logic        send_request, send_end, send_renew, start_tx, stop_tx;
  logic        indicate_grant, indicate_fail, warn_max_talk;
  logic [31:0] current_stream;
  logic [1:0]  node_state;

  int          mismatches, outstanding;
  logic        quiet = 1'b0;
  int          sent;
  logic [31:0] ms;
  int unsigned pace;

  ptt_floor_request_node uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .now(now),
    .out_valid(out_valid), .out_ready(out_ready),
    .send_request(send_request), .send_end(send_end), .send_renew(send_renew),
    .start_tx(start_tx), .stop_tx(stop_tx), .indicate_grant(indicate_grant),
    .indicate_fail(indicate_fail), .warn_max_talk(warn_max_talk),
    .current_stream(current_stream), .node_state(node_state)
  );

  floor_node_checker node_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .now(now),
    .out_valid(out_valid), .out_ready(out_ready),
    .send_request(send_request), .send_end(send_end), .send_renew(send_renew),
    .start_tx(start_tx), .stop_tx(stop_tx), .indicate_grant(indicate_grant),
    .indicate_fail(indicate_fail), .warn_max_talk(warn_max_talk),
    .current_stream(current_stream), .node_state(node_state),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side backpressure
  initial begin
    int   run;
    logic level;
    out_ready = 1'b0;
    forever begin
      run = $urandom_range(1, 16);
      level = quiet || ($urandom_range(0, 2) != 0);
      repeat (run) @(negedge clk) out_ready <= level;
    end
  end

  function automatic logic [31:0] next_ms();
    ms = ms + $urandom_range(0, pace);
    return ms;
  endfunction

  task automatic put_event(input logic [2:0] ev, input logic [31:0] t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= ev;
    now <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk) cfg_write <= 1'b0;
  endtask

  task automatic load_settings(input logic [31:0] g, r, rn, mt, er, ei, fs);
    write_reg(pfr_pkg::REG_GRANT_TIMEOUT, g);
    write_reg(pfr_pkg::REG_REQUEST_LIMIT, r);
    write_reg(pfr_pkg::REG_RENEW_INTERVAL, rn);
    write_reg(pfr_pkg::REG_MAX_TALK, mt);
    write_reg(pfr_pkg::REG_END_BURST, er);
    write_reg(pfr_pkg::REG_END_INTERVAL, ei);
    write_reg(pfr_pkg::REG_FIRST_STREAM, fs);
  endtask

  task automatic floor_session();
    int pick;
    put_event(pfr_pkg::EV_DOWN, next_ms());
    repeat ($urandom_range(0, 4)) put_event(pfr_pkg::EV_TICK, next_ms());
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      put_event(pfr_pkg::EV_GRANT, next_ms());
      repeat ($urandom_range(2, 10))
        put_event(($urandom_range(0, 2) == 0) ? pfr_pkg::EV_VOICE : pfr_pkg::EV_TICK,
                  next_ms());
      pick = $urandom_range(0, 5);
      put_event((pick <= 3) ? pfr_pkg::EV_UP :
                ((pick == 4) ? pfr_pkg::EV_DENY : pfr_pkg::EV_LOSS), next_ms());
    end else if (pick == 6) begin
      put_event(pfr_pkg::EV_DENY, next_ms());
    end else if (pick == 7) begin
      put_event(pfr_pkg::EV_UP, next_ms());
    end else if (pick == 8) begin
      put_event(pfr_pkg::EV_LOSS, next_ms());
    end
    repeat ($urandom_range(0, 5)) put_event(pfr_pkg::EV_TICK, next_ms());
  endtask

  task automatic stray_events();
    repeat ($urandom_range(1, 3)) put_event(3'($urandom_range(0, 7)), $urandom());
  endtask

  initial begin
    logic [31:0] t0;
    int          stop_at;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = pfr_pkg::REG_GRANT_TIMEOUT;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = pfr_pkg::EV_TICK;
    now = '0;
    quiet = 1'b0;
    sent = 0;
    ms = '0;
    pace = 1;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: reset settings, time base wraps through zero
    t0 = 32'hFFFF_FF80;
    put_event(EV_NONE, 32'hFFFF_FFFF);
    put_event(pfr_pkg::EV_LOSS, 32'h0000_0000);
    put_event(pfr_pkg::EV_UP, t0);
    put_event(pfr_pkg::EV_DOWN, t0);
    put_event(pfr_pkg::EV_TICK, t0 + 32'd99);
    put_event(pfr_pkg::EV_TICK, t0 + 32'd100);
    put_event(pfr_pkg::EV_TICK, t0 + 32'd200);
    put_event(pfr_pkg::EV_TICK, t0 + 32'd300);   // retries used up
    put_event(pfr_pkg::EV_DOWN, t0 + 32'd310);
    put_event(pfr_pkg::EV_LOSS, t0 + 32'd320);
    put_event(pfr_pkg::EV_DOWN, t0 + 32'd330);
    put_event(pfr_pkg::EV_DENY, t0 + 32'd340);
    put_event(pfr_pkg::EV_DOWN, t0 + 32'd350);
    put_event(pfr_pkg::EV_UP, t0 + 32'd360);
    put_event(pfr_pkg::EV_DOWN, t0 + 32'd370);   // new request from ending
    put_event(pfr_pkg::EV_GRANT, t0 + 32'd380);
    put_event(pfr_pkg::EV_VOICE, t0 + 32'd500);
    put_event(pfr_pkg::EV_TICK, t0 + 32'd750);
    put_event(pfr_pkg::EV_DENY, t0 + 32'd800);
    put_event(pfr_pkg::EV_DOWN, t0 + 32'd900);
    put_event(pfr_pkg::EV_GRANT, t0 + 32'd910);
    put_event(pfr_pkg::EV_TICK, t0 + 32'd121010);   // talk limit
    put_event(pfr_pkg::EV_TICK, t0 + 32'd121060);
    put_event(pfr_pkg::EV_TICK, t0 + 32'd121110);
    put_event(pfr_pkg::EV_LOSS, t0 + 32'd121120);
    put_event(pfr_pkg::EV_DOWN, t0 + 32'd121200);
    put_event(pfr_pkg::EV_GRANT, t0 + 32'd121210);
    put_event(pfr_pkg::EV_LOSS, t0 + 32'd121220);

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin
          load_settings(40, 3, 60, 400, 3, 20, $urandom());
          pace = 30;
        end
        1: begin
          load_settings(0, 0, 0, 0, 0, 0, 0);
          pace = 5;
        end
        2: begin
          load_settings('1, 32'hFF, '1, '1, 32'hFF, '1, '1);
          pace = 1000;
        end
        3: begin
          load_settings($urandom_range(0, 150), $urandom_range(0, 6), $urandom_range(0, 200),
                        $urandom_range(50, 1500), $urandom_range(0, 5),
                        $urandom_range(0, 80), 32'hFFFF_FFFE);
          pace = 60;
        end
        default: begin
          load_settings($urandom_range(0, 150),
                        ($urandom() & 32'hFFFF_FF00) | $urandom_range(0, 6),
                        $urandom_range(0, 200), $urandom_range(50, 1500),
                        ($urandom() & 32'hFFFF_FF00) | $urandom_range(0, 5),
                        $urandom_range(0, 80), $urandom());
          if (p == 4) write_reg(REG_UNUSED, $urandom());
          if (p == 5) write_reg(pfr_pkg::REG_REQUEST_LIMIT, 32'd255);
          pace = $urandom_range(10, 120);
        end
      endcase
      if (p == 7) quiet = 1'b1;
      ms = $urandom();
      stop_at = sent + 55;
      while (sent < stop_at) begin
        if ($urandom_range(0, 9) == 0) stray_events();
        else floor_session();
      end
    end

    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
